/* src/pcgb_pkg.sv */
// pcgb_pkg: widths, constants and codes of the pcg32 bounded generator
// no dependencies; used by the channel interfaces, the core, the checker and the testbench
package pcgb_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned STATE_W   = 64;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CNT_W     = $clog2(WORD_W);

  // lcg multiplier and reset values
  localparam logic [STATE_W-1:0] LCG_MULT   = 64'h5851_f42d_4c95_7f2d;
  localparam logic [STATE_W-1:0] SEED_RESET = 64'h853c_49e6_748f_ea9b;
  localparam logic [STATE_W-1:0] INC_RESET  = 64'hda3e_39cb_94b9_5bdb;

  // xsh-rr permutation taps
  localparam int unsigned XS_SHIFT = 18;
  localparam int unsigned XS_LSB   = 27;
  localparam int unsigned ROT_LSB  = 59;

  // request commands
  localparam logic CMD_RAW     = 1'b0;
  localparam logic CMD_BOUNDED = 1'b1;

  // result status
  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_ZERO_RANGE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT = 1'b1;

endpackage

/* src/pcgb_req_if.sv */
// pcgb_req_if: request channel (command, range) with valid/ready
// depends on pcgb_pkg
interface pcgb_req_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [pcgb_pkg::WORD_W-1:0]  range;

  modport source (output valid, output command, output range, input ready);
  modport sink   (input valid, input command, input range, output ready);
endinterface

/* src/pcgb_rsp_if.sv */
// pcgb_rsp_if: result channel (value, status) with valid/ready
// depends on pcgb_pkg
interface pcgb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pcgb_pkg::WORD_W-1:0]  value;
  logic                         status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

/* src/pcg32_bounded_generator_core.sv */
// pcg32_bounded_generator_core: pcg32 xsh-rr generator with bounded draws
// depends on pcgb_pkg, pcgb_req_if, pcgb_rsp_if
//
//  port      dir  payload           transfer when
//  req_i     in   command, range    req_i.valid && req_i.ready
//  rsp_o     out  value, status     rsp_o.valid && rsp_o.ready
//  cfg_*_i   in   index, data       cfg_we_i high (no handshake)
//
// raw draw: after the request transfer, S_MUL0, S_MUL1, S_MUL2, S_ADD, S_EMIT;
// one 32x32 multiplier is shared by the three partial products of the 64-bit
// lcg step and the draw*range product; a new request is taken only in idle.
// bounded draw: S_CHECK after S_ADD, plus the threshold remainder in S_DIV
// (one bit per cycle, then a recheck) when the low product word falls below
// range; each rejected candidate goes back to S_MUL0. zero range: to S_EMIT.
// reset loads the default seed and increment; a stalled result is held
// in the output register while the core already returns to idle.
module pcg32_bounded_generator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcgb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pcgb_pkg::STATE_W-1:0]     cfg_data_i,
  pcgb_req_if.sink                         req_i,
  pcgb_rsp_if.source                       rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_ADD,
    S_CHECK,
    S_DIV,
    S_EMIT
  } state_e;

  localparam int unsigned W  = pcgb_pkg::WORD_W;
  localparam int unsigned SW = pcgb_pkg::STATE_W;

  state_e                          state_q, state_d;
  logic [SW-1:0]                   lcg_q, lcg_d;
  logic [SW-1:0]                   inc_q, inc_d;
  logic [SW-1:0]                   acc_q, acc_d;
  logic [2*W-1:0]                  prod_q, prod_d;
  logic [W-1:0]                    draw_q, draw_d;
  logic                            cmd_q, cmd_d;
  logic [W-1:0]                    range_q, range_d;
  logic [W-1:0]                    rem_q, rem_d;
  logic [W-1:0]                    dnd_q, dnd_d;
  logic [pcgb_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                            thr_valid_q, thr_valid_d;
  logic [W-1:0]                    res_value_q, res_value_d;
  logic                            res_status_q, res_status_d;
  logic                            rsp_valid_q, rsp_valid_d;
  logic [W-1:0]                    rsp_value_q, rsp_value_d;
  logic                            rsp_status_q, rsp_status_d;

  // shared multiplier
  logic [W-1:0]                    mul_a, mul_b;
  logic [2*W-1:0]                  mul_res;

  // divider step
  logic [W:0]                      div_sh;
  logic                            div_ge;

  logic [W-1:0]                    xs_rr;
  logic [W-1:0]                    prod_lo;
  logic                            req_xfer;
  logic                            rsp_free;

  // xsh-rr output permutation of the current (old) state
  function automatic logic [pcgb_pkg::WORD_W-1:0] xsh_rr(
    input logic [pcgb_pkg::STATE_W-1:0] s
  );
    logic [pcgb_pkg::STATE_W-1:0]   mix;
    logic [pcgb_pkg::WORD_W-1:0]    xs;
    logic [4:0]                     rot;
    logic [2*pcgb_pkg::WORD_W-1:0]  dbl;
    mix = (s >> pcgb_pkg::XS_SHIFT) ^ s;
    xs  = mix[pcgb_pkg::XS_LSB +: pcgb_pkg::WORD_W];
    rot = s[pcgb_pkg::ROT_LSB +: 5];
    dbl = {xs, xs} >> rot;
    return dbl[pcgb_pkg::WORD_W-1:0];
  endfunction

  assign xs_rr    = xsh_rr(lcg_q);
  assign prod_lo  = prod_q[W-1:0];
  assign req_xfer = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.value  = rsp_value_q;
  assign rsp_o.status = rsp_status_q;

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = draw_q;
    mul_b = range_q;
    unique case (state_q)
      S_MUL0: begin
        mul_a = lcg_q[W-1:0];
        mul_b = pcgb_pkg::LCG_MULT[W-1:0];
      end
      S_MUL1: begin
        mul_a = lcg_q[W-1:0];
        mul_b = pcgb_pkg::LCG_MULT[SW-1:W];
      end
      S_MUL2: begin
        mul_a = lcg_q[SW-1:W];
        mul_b = pcgb_pkg::LCG_MULT[W-1:0];
      end
      default: begin
        mul_a = draw_q;
        mul_b = range_q;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  // restoring remainder step: (2^32 - range) mod range, one bit a cycle
  assign div_sh = {rem_q, dnd_q[W-1]};
  assign div_ge = (div_sh >= {1'b0, range_q});

  always_comb begin
    state_d      = state_q;
    lcg_d        = lcg_q;
    inc_d        = inc_q;
    acc_d        = acc_q;
    prod_d       = prod_q;
    draw_d       = draw_q;
    cmd_d        = cmd_q;
    range_d      = range_q;
    rem_d        = rem_q;
    dnd_d        = dnd_q;
    cnt_d        = cnt_q;
    thr_valid_d  = thr_valid_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    rsp_valid_d  = rsp_valid_q;
    rsp_value_d  = rsp_value_q;
    rsp_status_d = rsp_status_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    // configuration writes must arrive only while idle; the core itself does not enforce this
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        pcgb_pkg::CFG_SEED:      lcg_d = cfg_data_i;
        pcgb_pkg::CFG_INCREMENT: inc_d = cfg_data_i | {{(SW-1){1'b0}}, 1'b1};
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          cmd_d       = req_i.command;
          range_d     = req_i.range;
          thr_valid_d = 1'b0;
          if (req_i.command == pcgb_pkg::CMD_BOUNDED && req_i.range == '0) begin
            // zero range: error result, state untouched
            res_value_d  = '0;
            res_status_d = pcgb_pkg::STATUS_ZERO_RANGE;
            state_d      = S_EMIT;
          end else begin
            state_d = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        draw_d  = xs_rr;
        prod_d  = mul_res;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        // fold the increment in with the low partial product
        acc_d   = prod_q + inc_q;
        prod_d  = mul_res;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        acc_d[SW-1:W] = acc_q[SW-1:W] + prod_lo;
        prod_d        = mul_res;
        state_d       = S_ADD;
      end
      S_ADD: begin
        lcg_d  = {acc_q[SW-1:W] + prod_lo, acc_q[W-1:0]};
        prod_d = mul_res;
        if (cmd_q == pcgb_pkg::CMD_RAW) begin
          res_value_d  = draw_q;
          res_status_d = pcgb_pkg::STATUS_OK;
          state_d      = S_EMIT;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!thr_valid_q && prod_lo < range_q) begin
          // threshold needed: start the remainder
          rem_d   = '0;
          dnd_d   = '0 - range_q;
          cnt_d   = '0;
          state_d = S_DIV;
        end else if (thr_valid_q && prod_lo < rem_q) begin
          // rejected candidate: draw again
          state_d = S_MUL0;
        end else begin
          res_value_d  = prod_q[2*W-1:W];
          res_status_d = pcgb_pkg::STATUS_OK;
          state_d      = S_EMIT;
        end
      end
      S_DIV: begin
        rem_d = div_ge ? W'(div_sh - {1'b0, range_q}) : div_sh[W-1:0];
        dnd_d = {dnd_q[W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == pcgb_pkg::CNT_W'(W - 1)) begin
          thr_valid_d = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_EMIT: begin
        if (rsp_free) begin
          rsp_valid_d  = 1'b1;
          rsp_value_d  = res_value_q;
          rsp_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lcg_q       <= pcgb_pkg::SEED_RESET;
      inc_q       <= pcgb_pkg::INC_RESET | {{(SW-1){1'b0}}, 1'b1};
      thr_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      lcg_q       <= lcg_d;
      inc_q       <= inc_d;
      thr_valid_q <= thr_valid_d;
      rsp_valid_q <= rsp_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q        <= acc_d;
    prod_q       <= prod_d;
    draw_q       <= draw_d;
    cmd_q        <= cmd_d;
    range_q      <= range_d;
    rem_q        <= rem_d;
    dnd_q        <= dnd_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    rsp_value_q  <= rsp_value_d;
    rsp_status_q <= rsp_status_d;
  end

  // increment stays odd whatever is written
  assert property (@(posedge clk_i) disable iff (!rst_ni) inc_q[0])
    else $error("increment lost its low bit");

  // an error result never carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_status_q == pcgb_pkg::STATUS_ZERO_RANGE) |-> (rsp_value_q == '0))
    else $error("zero-range result with nonzero value");

  // a finished threshold is always below the range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (thr_valid_q && state_q == S_CHECK) |-> (rem_q < range_q))
    else $error("threshold not below range");

  // a request transfer always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> (state_q != S_IDLE))
    else $error("request transfer dropped");

  // a zero-range request leaves the generator state alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_xfer && req_i.command == pcgb_pkg::CMD_BOUNDED && req_i.range == '0 && !cfg_we_i)
      |=> $stable(lcg_q))
    else $error("zero-range request advanced the state");

endmodule

/* dv/pcgb_draw_checker.sv */
`timescale 1ns / 100ps
// pcgb_draw_checker: watches the config port and both channels of the pcg32 core,
// predicts every result from its own copy of the generator and compares in order
// depends on pcgb_pkg
module pcgb_draw_checker
  import pcgb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [STATE_W-1:0]    cfg_data_i,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  logic                  req_command_i,
  input  logic [WORD_W-1:0]     req_bound_i,
  input  logic                  rsp_valid_i,
  input  logic                  rsp_ready_i,
  input  logic [WORD_W-1:0]     rsp_value_i,
  input  logic                  rsp_status_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_count_o
);

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              status;
  } draw_result_t;

  logic [STATE_W-1:0] gen_state;
  logic [STATE_W-1:0] gen_increment;
  draw_result_t       expected_draws[$];
  draw_result_t       oldest;

  // one lcg step, xsh-rr of the state before the step
  function automatic logic [WORD_W-1:0] next_word();
    logic [STATE_W-1:0]  prior;
    logic [WORD_W-1:0]   xs;
    logic [2*WORD_W-1:0] doubled;
    prior     = gen_state;
    gen_state = prior * LCG_MULT + gen_increment;
    xs        = WORD_W'(((prior >> XS_SHIFT) ^ prior) >> XS_LSB);
    doubled   = {xs, xs} >> prior[STATE_W-1:ROT_LSB];
    return doubled[WORD_W-1:0];
  endfunction

  function automatic draw_result_t predict_draw(input logic cmd, input logic [WORD_W-1:0] bound);
    draw_result_t        res;
    logic [2*WORD_W-1:0] prod;
    logic [WORD_W-1:0]   thresh;
    res.value  = '0;
    res.status = STATUS_OK;
    if (cmd == CMD_RAW) begin
      res.value = next_word();
    end else if (bound == '0) begin
      res.status = STATUS_ZERO_RANGE;
    end else begin
      prod = (2*WORD_W)'(next_word()) * (2*WORD_W)'(bound);
      // threshold only needed when the low word lands under the bound
      if (prod[WORD_W-1:0] < bound) begin
        thresh = (-bound) % bound;
        while (prod[WORD_W-1:0] < thresh) begin
          prod = (2*WORD_W)'(next_word()) * (2*WORD_W)'(bound);
        end
      end
      res.value = prod[2*WORD_W-1:WORD_W];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_state        = SEED_RESET;
      gen_increment    = INC_RESET | 64'd1;
      expected_draws.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SEED) gen_state = cfg_data_i;
        else if (cfg_index_i == CFG_INCREMENT) gen_increment = cfg_data_i | 64'd1;
      end
      if (req_valid_i && req_ready_i) begin
        expected_draws.push_back(predict_draw(req_command_i, req_bound_i));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_draws.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected result, expected none, actual value %h status %0d",
                   $time, rsp_value_i, rsp_status_i);
        end else begin
          oldest = expected_draws.pop_front();
          if (rsp_value_i !== oldest.value) begin
            mismatch_count_o++;
            $display("%0t: value mismatch, expected %h, actual %h",
                     $time, oldest.value, rsp_value_i);
          end
          if (rsp_status_i !== oldest.status) begin
            mismatch_count_o++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, oldest.status, rsp_status_i);
          end
        end
      end
      pending_count_o = expected_draws.size();
    end
  end

endmodule

/* dv/pcg32_bounded_generator_core_tb.sv */
`timescale 1ns / 100ps
// pcg32_bounded_generator_core_tb: drives requests, config writes and result stalls,
// leaves prediction to pcgb_draw_checker and prints the verdict
// depends on pcgb_pkg, pcgb_req_if, pcgb_rsp_if, pcg32_bounded_generator_core, pcgb_draw_checker
module pcg32_bounded_generator_core_tb;
  import pcgb_pkg::*;

  localparam int unsigned PHASE_DRAWS  = 255;  // random requests per config phase
  localparam int unsigned PHASE_COUNT  = 6;
  localparam int unsigned SETTLE_CYCLES = 8;   // core is idle once the last result is out
  localparam int unsigned DRAIN_CYCLES = 64;   // longer than a bounded draw with remainder

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STATE_W-1:0] cfg_data;

  // when set, neither side idles, so back-to-back transfers get exercised
  bit                 steady;
  int unsigned        stall_left;
  int unsigned        mismatch_count;
  int unsigned        pending_count;

  pcgb_req_if req_ch ();
  pcgb_rsp_if rsp_ch ();

  pcg32_bounded_generator_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  pcgb_draw_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .req_valid_i      (req_ch.valid),
    .req_ready_i      (req_ch.ready),
    .req_command_i    (req_ch.command),
    .req_bound_i      (req_ch.range),
    .rsp_valid_i      (rsp_ch.valid),
    .rsp_ready_i      (rsp_ch.ready),
    .rsp_value_i      (rsp_ch.value),
    .rsp_status_i     (rsp_ch.status),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case a transfer never completes
  initial begin
    #10_000_000;
    $display("[pcg32_bounded_generator_core] ERROR");
    $finish;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // bounds chosen to hit the rare paths: zero, one, tiny, small, just below 2^32, powers of two,
  // and just above half of 2^32 where almost half of all candidates get rejected; else any value
  function automatic logic [WORD_W-1:0] pick_bound();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return $urandom_range(2, 16);
      3:       return $urandom_range(17, 1000);
      4:       return 32'h8000_0000 + $urandom_range(0, 8);
      5:       return 32'hffff_ffff - $urandom_range(0, 8);
      6:       return 32'd1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // result side: ready drops for a random stall, one assignment per edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      stall_left   <= pick_gap();
    end
  end

  // one request transfer; valid stays high across back-to-back requests
  task automatic push_request(input logic cmd, input logic [WORD_W-1:0] bound);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.range   <= bound;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // hold off requests until every outstanding draw has come back
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_registers(input bit do_seed, input logic [STATE_W-1:0] seed,
                                input bit do_inc, input logic [STATE_W-1:0] inc);
    if (do_seed) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_SEED;
      cfg_data  <= seed;
      @(posedge clk_i);
    end
    if (do_inc) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INCREMENT;
      cfg_data  <= inc;
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      // mid-phase drain: the sender waits for the result side to empty
      if (i == count / 2) wait_for_results();
      push_request(($urandom_range(0, 9) < 3) ? CMD_RAW : CMD_BOUNDED, pick_bound());
    end
    steady = 1'b0;
  endtask

  initial begin
    logic [STATE_W-1:0] seed;
    logic [STATE_W-1:0] inc;
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_SEED;
    cfg_data       <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.command <= CMD_RAW;
    req_ch.range   <= '0;
    steady          = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset seed and increment
    push_request(CMD_RAW, '0);                  // raw draw, bound ignored
    push_request(CMD_RAW, 32'hffff_ffff);       // raw draw with a full bound field
    push_request(CMD_BOUNDED, '0);              // zero bound: error, no draw
    push_request(CMD_BOUNDED, 32'd1);           // bound of one: always zero, still draws
    push_request(CMD_BOUNDED, 32'd2);
    push_request(CMD_BOUNDED, 32'd3);
    push_request(CMD_BOUNDED, 32'hffff_ffff);   // widest bound
    push_request(CMD_BOUNDED, 32'h8000_0000);   // power of two: threshold is zero
    push_request(CMD_BOUNDED, 32'h8000_0001);   // worst rejection rate
    push_request(CMD_BOUNDED, 32'h8000_0001);
    push_request(CMD_BOUNDED, 32'h8000_0001);
    push_request(CMD_BOUNDED, 32'h8000_0003);
    push_request(CMD_BOUNDED, 32'd7);
    push_request(CMD_BOUNDED, 32'h5555_5555);
    push_request(CMD_BOUNDED, 32'haaaa_aaab);
    push_request(CMD_BOUNDED, '0);              // zero bound twice in a row
    push_request(CMD_BOUNDED, '0);
    push_request(CMD_RAW, 32'h1234_5678);
    push_request(CMD_BOUNDED, 32'd1);
    push_request(CMD_BOUNDED, 32'hffff_fffe);
    wait_for_results();

    // random phases, each behind its own register setting
    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      seed = {$urandom(), $urandom()};
      inc  = {$urandom(), $urandom()};
      case (p)
        0:       load_registers(1'b1, '0, 1'b1, '0);          // zero seed, increment forced to one
        1:       load_registers(1'b1, '1, 1'b1, '1);          // all ones on both
        2:       load_registers(1'b1, seed, 1'b1, inc);
        3:       load_registers(1'b1, seed, 1'b0, inc);       // reseed, keep stream
        4:       load_registers(1'b0, seed, 1'b1, 64'h8000_0000_0000_0000);  // even increment
        default: load_registers(1'b1, SEED_RESET, 1'b1, inc & ~64'd1);
      endcase
      random_phase(PHASE_DRAWS);
      wait_for_results();
    end

    // final drain then verdict
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[pcg32_bounded_generator_core] OK");
    end else begin
      $display("[pcg32_bounded_generator_core] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/pcgb_pkg.sv
src/pcgb_req_if.sv
src/pcgb_rsp_if.sv
src/pcg32_bounded_generator_core.sv
dv/pcgb_draw_checker.sv
dv/pcg32_bounded_generator_core_tb.sv
